@@ src/http_body_length_guard_defines.svh @@
// Assertion macros for the body length guard checks.
`ifndef HTTP_BODY_LENGTH_GUARD_DEFINES_SVH
`define HTTP_BODY_LENGTH_GUARD_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define HBG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("body length guard check failed");

// Check a property on every clock edge, reset included.
`define HBG_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("body length guard check failed");

`endif

@@ src/hbg_pkg.sv @@
// Shared types and constants for the body length guard.
`timescale 1ns / 1ps
`default_nettype none
package hbg_pkg;

  localparam int unsigned BUF_DEPTH_DEF = 2048;

  localparam int unsigned PHASE_W  = 3;
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned LEN_W    = 32;
  localparam int unsigned KEPT_W   = 12;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned INDEX_W  = 11;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [PHASE_W-1:0] PH_IDLE      = 3'd0;
  localparam logic [PHASE_W-1:0] PH_COLLECT   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_NO_LENGTH = 3'd2;
  localparam logic [PHASE_W-1:0] PH_TOO_LARGE = 3'd3;
  localparam logic [PHASE_W-1:0] PH_ABORT     = 3'd4;
  localparam logic [PHASE_W-1:0] PH_TRUNCATED = 3'd5;

  localparam logic [ACTION_W-1:0] ACT_RESET = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_START = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_DATA  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_END   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_ABORT = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_READ  = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_BODY_LIMIT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DRAIN_LIMIT = 1'd1;

  localparam logic [KEPT_W-1:0] BODY_LIMIT_RST  = 12'd2048;
  localparam logic [LEN_W-1:0]  DRAIN_LIMIT_RST = 32'd16384;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               ready;
    logic [KEPT_W-1:0]  ready_len;
    logic [LEN_W-1:0]   seen;
    logic               rd;
  } result_t;

endpackage
`default_nettype wire

@@ src/hbg_ram.sv @@
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module hbg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2048,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ src/hbg_ctrl.sv @@
// Body state registers, per-item update and store access stage.
`timescale 1ns / 1ps
`default_nettype none
module hbg_ctrl #(
  parameter int unsigned BUF_DEPTH = hbg_pkg::BUF_DEPTH_DEF,
  localparam int unsigned AW    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1,
  localparam int unsigned LENW  = $clog2(BUF_DEPTH + 1),
  localparam int unsigned CMPW  = (LENW > hbg_pkg::KEPT_W) ? LENW : hbg_pkg::KEPT_W
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           accept_i,
  input  wire logic [hbg_pkg::ACTION_W-1:0]   action_i,
  input  wire logic signed [hbg_pkg::LEN_W-1:0] declared_length_i,
  input  wire logic [hbg_pkg::INDEX_W-1:0]    read_index_i,
  input  wire logic [hbg_pkg::KEPT_W-1:0]     body_limit_i,
  input  wire logic [hbg_pkg::LEN_W-1:0]      drain_limit_i,
  input  wire logic                           take_i,
  output logic                                s1_valid_o,
  output hbg_pkg::result_t                    s1_res_o,
  output logic                                we_o,
  output logic [AW-1:0]                       waddr_o,
  output logic                                re_o,
  output logic [AW-1:0]                       raddr_o
);

  logic [hbg_pkg::PHASE_W-1:0] phase_q, phase_d;
  logic [hbg_pkg::LEN_W-1:0]   declared_q, declared_d;
  logic [hbg_pkg::LEN_W-1:0]   seen_q, seen_d;
  logic [hbg_pkg::KEPT_W-1:0]  kept_q, kept_d;
  logic                        s1_valid_q, s1_valid_d;
  hbg_pkg::result_t            s1_res_q, s1_res_d;

  logic [CMPW-1:0]             keep_lim;
  logic [CMPW-1:0]             kept_ext;
  logic [CMPW-1:0]             ridx_ext;
  logic [hbg_pkg::LEN_W-1:0]   decl_raw;
  logic                        full;
  logic                        ready_d;
  logic                        rd;

  assign decl_raw = declared_length_i;
  assign keep_lim = (CMPW'(body_limit_i) < CMPW'(BUF_DEPTH)) ?
                    CMPW'(body_limit_i) : CMPW'(BUF_DEPTH);
  assign kept_ext = CMPW'(kept_q);
  assign ridx_ext = CMPW'(read_index_i);
  assign full     = kept_ext >= keep_lim;

  always_comb begin
    phase_d    = phase_q;
    declared_d = declared_q;
    seen_d     = seen_q;
    kept_d     = kept_q;
    we_o       = 1'b0;
    if (accept_i) begin
      unique case (action_i)
        hbg_pkg::ACT_RESET: begin
          phase_d    = hbg_pkg::PH_IDLE;
          declared_d = '0;
          seen_d     = '0;
          kept_d     = '0;
        end
        hbg_pkg::ACT_START: begin
          declared_d = '0;
          seen_d     = '0;
          kept_d     = '0;
          if (decl_raw[hbg_pkg::LEN_W-1]) begin
            phase_d = hbg_pkg::PH_ABORT;
          end else begin
            declared_d = decl_raw;
            priority if (decl_raw == '0) begin
              phase_d = hbg_pkg::PH_NO_LENGTH;
            end else if (decl_raw > drain_limit_i) begin
              phase_d = hbg_pkg::PH_ABORT;
            end else if (decl_raw > hbg_pkg::LEN_W'(body_limit_i)) begin
              phase_d = hbg_pkg::PH_TOO_LARGE;
            end else begin
              phase_d = hbg_pkg::PH_COLLECT;
            end
          end
        end
        hbg_pkg::ACT_DATA: begin
          seen_d = seen_q + hbg_pkg::LEN_W'(1);
          if (phase_q == hbg_pkg::PH_COLLECT) begin
            if (full) begin
              phase_d = hbg_pkg::PH_TOO_LARGE;
              kept_d  = '0;
            end else begin
              we_o   = 1'b1;
              kept_d = kept_q + hbg_pkg::KEPT_W'(1);
            end
          end
        end
        hbg_pkg::ACT_END: begin
          if (phase_q == hbg_pkg::PH_COLLECT && seen_q < declared_q) begin
            phase_d = hbg_pkg::PH_TRUNCATED;
            kept_d  = '0;
          end
        end
        hbg_pkg::ACT_ABORT: begin
          phase_d = hbg_pkg::PH_ABORT;
          kept_d  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  assign ready_d = (phase_d == hbg_pkg::PH_COLLECT) && (kept_d != '0) &&
                   (hbg_pkg::LEN_W'(kept_d) == declared_d) && (seen_d == declared_d);
  assign rd      = accept_i && (action_i == hbg_pkg::ACT_READ) && ready_d &&
                   (ridx_ext < CMPW'(kept_d));

  assign re_o    = rd;
  assign waddr_o = kept_ext[AW-1:0];
  assign raddr_o = ridx_ext[AW-1:0];

  always_comb begin
    s1_res_d           = s1_res_q;
    s1_res_d.phase     = phase_d;
    s1_res_d.ready     = ready_d;
    s1_res_d.ready_len = ready_d ? kept_d : '0;
    s1_res_d.seen      = seen_d;
    s1_res_d.rd        = rd;
    s1_valid_d         = accept_i ? 1'b1 : (take_i ? 1'b0 : s1_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= hbg_pkg::PH_IDLE;
      declared_q <= '0;
      seen_q     <= '0;
      kept_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      declared_q <= declared_d;
      seen_q     <= seen_d;
      kept_q     <= kept_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_res_q <= s1_res_d;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_res_o   = s1_res_q;

endmodule
`default_nettype wire

@@ src/hbg_out.sv @@
// Result output register, merges store read data into the result beat.
`timescale 1ns / 1ps
`default_nettype none
module hbg_out (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s1_valid_i,
  input  wire hbg_pkg::result_t            s1_res_i,
  input  wire logic [hbg_pkg::BYTE_W-1:0]  rdata_i,
  output logic                             take_o,
  input  wire logic                        out_ready_i,
  output logic                             out_valid_o,
  output logic [hbg_pkg::PHASE_W-1:0]      phase_code_o,
  output logic                             body_ready_o,
  output logic [hbg_pkg::KEPT_W-1:0]       ready_length_o,
  output logic [hbg_pkg::LEN_W-1:0]        bytes_seen_o,
  output logic [hbg_pkg::BYTE_W-1:0]       read_byte_o
);

  logic                        out_valid_q, out_valid_d;
  logic [hbg_pkg::PHASE_W-1:0] phase_q;
  logic                        ready_q;
  logic [hbg_pkg::KEPT_W-1:0]  len_q;
  logic [hbg_pkg::LEN_W-1:0]   seen_q;
  logic [hbg_pkg::BYTE_W-1:0]  byte_q;

  assign take_o      = s1_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_d = take_o ? 1'b1 : ((out_valid_q && out_ready_i) ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      phase_q <= s1_res_i.phase;
      ready_q <= s1_res_i.ready;
      len_q   <= s1_res_i.ready_len;
      seen_q  <= s1_res_i.seen;
      byte_q  <= s1_res_i.rd ? rdata_i : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign phase_code_o   = phase_q;
  assign body_ready_o   = ready_q;
  assign ready_length_o = len_q;
  assign bytes_seen_o   = seen_q;
  assign read_byte_o    = byte_q;

endmodule
`default_nettype wire

@@ src/http_body_length_guard.sv @@
// A result beat is registered in the stage-one result register and then in the output register before it is valid.
// Throughput: one item per cycle while the output is not stalled; the body store has one write and one read port.
// A stalled output holds one finished beat while the next item enters.
// Reset clears phase, counts, kept length and the limits to their defaults;
// the body store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module http_body_length_guard #(
  parameter int unsigned BUF_DEPTH = hbg_pkg::BUF_DEPTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [hbg_pkg::ACTION_W-1:0]      action_i,
  input  wire logic signed [hbg_pkg::LEN_W-1:0]  declared_length_i,
  input  wire logic [hbg_pkg::BYTE_W-1:0]        data_byte_i,
  input  wire logic [hbg_pkg::INDEX_W-1:0]       read_index_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [hbg_pkg::PHASE_W-1:0]            phase_code_o,
  output logic                                   body_ready_o,
  output logic [hbg_pkg::KEPT_W-1:0]             ready_length_o,
  output logic [hbg_pkg::LEN_W-1:0]              bytes_seen_o,
  output logic [hbg_pkg::BYTE_W-1:0]             read_byte_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [hbg_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [hbg_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

  logic [hbg_pkg::KEPT_W-1:0] body_limit_q;
  logic [hbg_pkg::LEN_W-1:0]  drain_limit_q;
  logic                       accept;
  logic                       take;
  logic                       s1_valid;
  hbg_pkg::result_t           s1_res;
  logic                       we;
  logic [AW-1:0]              waddr;
  logic                       re;
  logic [AW-1:0]              raddr;
  logic [hbg_pkg::BYTE_W-1:0] rdata;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !s1_valid || take;
  assign accept      = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      body_limit_q  <= hbg_pkg::BODY_LIMIT_RST;
      drain_limit_q <= hbg_pkg::DRAIN_LIMIT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        hbg_pkg::CFG_BODY_LIMIT:  body_limit_q  <= cfg_data_i[hbg_pkg::KEPT_W-1:0];
        hbg_pkg::CFG_DRAIN_LIMIT: drain_limit_q <= cfg_data_i[hbg_pkg::LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  hbg_ctrl #(
    .BUF_DEPTH(BUF_DEPTH)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .action_i         (action_i),
    .declared_length_i(declared_length_i),
    .read_index_i     (read_index_i),
    .body_limit_i     (body_limit_q),
    .drain_limit_i    (drain_limit_q),
    .take_i           (take),
    .s1_valid_o       (s1_valid),
    .s1_res_o         (s1_res),
    .we_o             (we),
    .waddr_o          (waddr),
    .re_o             (re),
    .raddr_o          (raddr)
  );

  hbg_ram #(
    .WIDTH(hbg_pkg::BYTE_W),
    .DEPTH(BUF_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(data_byte_i),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  hbg_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s1_valid_i    (s1_valid),
    .s1_res_i      (s1_res),
    .rdata_i       (rdata),
    .take_o        (take),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .phase_code_o  (phase_code_o),
    .body_ready_o  (body_ready_o),
    .ready_length_o(ready_length_o),
    .bytes_seen_o  (bytes_seen_o),
    .read_byte_o   (read_byte_o)
  );

endmodule
`default_nettype wire

@@ src/hbg_chk.sv @@
// Port-level checks for the body length guard, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "http_body_length_guard_defines.svh"
module hbg_chk (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_valid_i,
  input wire logic                              in_ready_o,
  input wire logic                              out_valid_o,
  input wire logic                              out_ready_i,
  input wire logic [hbg_pkg::PHASE_W-1:0]       phase_code_o,
  input wire logic                              body_ready_o,
  input wire logic [hbg_pkg::KEPT_W-1:0]        ready_length_o,
  input wire logic [hbg_pkg::LEN_W-1:0]         bytes_seen_o,
  input wire logic [hbg_pkg::BYTE_W-1:0]        read_byte_o
);

  `HBG_ASSERT(a_ready_collect, out_valid_o && body_ready_o |-> phase_code_o == hbg_pkg::PH_COLLECT)
  `HBG_ASSERT(a_ready_len, out_valid_o && body_ready_o |-> ready_length_o != '0)
  `HBG_ASSERT(a_not_ready_zero, out_valid_o && !body_ready_o |-> ready_length_o == '0 && read_byte_o == '0)
  `HBG_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(bytes_seen_o))
  `HBG_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !out_valid_o)

endmodule

bind http_body_length_guard hbg_chk u_hbg_chk (.*);
`default_nettype wire
